[rtl/mocell_pkg.sv]
`timescale 1ns / 1ps

package mocell_pkg;

    localparam int CELLS       = 5;
    localparam int NEIGHBORS   = 4;
    localparam int FIELD_W     = 32;
    localparam int DAMP_W      = 17;
    localparam int EPS_W       = 16;
    localparam int FLOW_W      = 31;
    localparam int FRAC_BITS   = 16;
    localparam int LVL_W       = 34;
    localparam int SUM_W       = 36;
    localparam int DIFF_W      = 35;
    localparam int PROD_W      = DIFF_W + DAMP_W;
    localparam int CNT_W       = 3;
    localparam int CELL_IDX_W  = 3;
    localparam int NB_IDX_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DAMP_W;

    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = SUM_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);
    localparam int DIV_REM_W          = CNT_W;

    localparam logic [DAMP_W-1:0] DAMPING_RESET = DAMP_W'(32768);
    localparam logic [EPS_W-1:0]  EPSILON_RESET = EPS_W'(66);
    localparam logic [FLOW_W-1:0] FLOW_MAX      = {FLOW_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = CFG_IDX_W'(1);

    typedef logic signed [LVL_W-1:0] level_t;
    typedef logic signed [SUM_W-1:0] sum_t;

endpackage

[rtl/mocell_div.sv]
`timescale 1ns / 1ps

module mocell_div
    import mocell_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  sum_t             dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output sum_t             quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [SUM_W-1:0]     q_reg;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [CNT_W-1:0]     d_reg;
    logic                 neg_reg;
    sum_t                 quo_reg;

    logic [SUM_W-1:0]     q_next;
    logic [DIV_REM_W-1:0] rem_next;

    // Restoring division, several quotient bits per cycle on a narrow remainder.
    always_comb begin
        logic [DIV_REM_W:0] t;
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            t      = {rem_next, q_next[SUM_W-1]};
            q_next = {q_next[SUM_W-2:0], 1'b0};
            if (t >= {1'b0, d_reg}) begin
                rem_next  = DIV_REM_W'(t - {1'b0, d_reg});
                q_next[0] = 1'b1;
            end else begin
                rem_next = t[DIV_REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                neg_reg  <= dividend[SUM_W-1];
                q_reg    <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
                rem_reg  <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                q_reg    <= q_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo_reg  <= neg_reg ? -$signed(q_next) : $signed(q_next);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/minimization_outflow_cell.sv]
`timescale 1ns / 1ps

// Computes the four outflows of one cell by the minimization algorithm of the
// differences. A request is taken only when the block is idle. Each elimination
// pass sums through one adder, divides in the one divider at four quotient bits
// per cycle and then compares; there are one to six passes, and after them come
// the four damping products through one multiplier and the hand-off to the output
// register. A pass with no cell left skips the divider. A finished result waits
// in the output register while the next request is already being worked on.

module minimization_outflow_cell
    import mocell_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_center_altitude,
    input  logic signed [FIELD_W-1:0] s_center_thickness,
    input  logic signed [FIELD_W-1:0] s_north_level,
    input  logic signed [FIELD_W-1:0] s_west_level,
    input  logic signed [FIELD_W-1:0] s_east_level,
    input  logic signed [FIELD_W-1:0] s_south_level,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FLOW_W-1:0]         m_flow_north,
    output logic [FLOW_W-1:0]         m_flow_west,
    output logic [FLOW_W-1:0]         m_flow_east,
    output logic [FLOW_W-1:0]         m_flow_south
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ELIM,
        ST_FLOW,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [DAMP_W-1:0]     damping_reg;
    logic [EPS_W-1:0]      epsilon_reg;
    level_t                lvl_reg [CELLS];
    level_t                mass_reg;
    logic [CELLS-1:0]      gone_reg;
    logic [CELL_IDX_W-1:0] k_reg;
    logic [CNT_W-1:0]      cnt_reg;
    sum_t                  acc_reg;
    sum_t                  avg_reg;
    logic [DIFF_W-1:0]     diff_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [FLOW_W-1:0]     res_reg [NEIGHBORS];
    logic                  m_valid_reg;
    logic [FLOW_W-1:0]     flow_n_reg;
    logic [FLOW_W-1:0]     flow_w_reg;
    logic [FLOW_W-1:0]     flow_e_reg;
    logic [FLOW_W-1:0]     flow_s_reg;

    sum_t                  acc_next;
    logic [CNT_W-1:0]      cnt_next;
    logic [CELLS-1:0]      gone_next;
    logic [CELL_IDX_W-1:0] nb_idx;
    sum_t                  diff_full;
    logic [PROD_W-1:0]     prod_next;
    logic [PROD_W-FRAC_BITS-1:0] shifted;
    logic [FLOW_W-1:0]     sat_flow;
    logic [NB_IDX_W-1:0]   res_idx;
    level_t                eps_ext;
    logic                  div_done;
    sum_t                  div_quo;

    assign eps_ext = $signed({{(LVL_W - EPS_W){1'b0}}, epsilon_reg});

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (!gone_reg[k_reg]) begin
            acc_next = acc_reg + SUM_W'(lvl_reg[k_reg]);
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        gone_next = gone_reg;
        for (int i = 0; i < CELLS; i++) begin
            if (!gone_reg[i] && (avg_reg <= SUM_W'(lvl_reg[i]))) begin
                gone_next[i] = 1'b1;
            end
        end
    end

    assign nb_idx    = k_reg + CELL_IDX_W'(1);
    assign diff_full = avg_reg - SUM_W'(lvl_reg[nb_idx]);
    assign prod_next = PROD_W'(diff_reg) * PROD_W'(damping_reg);
    assign shifted   = prod_reg[PROD_W-1:FRAC_BITS];
    assign sat_flow  = (|shifted[PROD_W-FRAC_BITS-1:FLOW_W]) ? FLOW_MAX
                                                              : shifted[FLOW_W-1:0];
    assign res_idx   = NB_IDX_W'(k_reg - CELL_IDX_W'(2));

    mocell_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (acc_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            damping_reg <= DAMPING_RESET;
            epsilon_reg <= EPSILON_RESET;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DAMPING: damping_reg <= cfg_wdata[DAMP_W-1:0];
                    REG_EPSILON: epsilon_reg <= cfg_wdata[EPS_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        lvl_reg[0] <= LVL_W'(s_center_altitude) + eps_ext;
                        lvl_reg[1] <= LVL_W'(s_north_level);
                        lvl_reg[2] <= LVL_W'(s_west_level);
                        lvl_reg[3] <= LVL_W'(s_east_level);
                        lvl_reg[4] <= LVL_W'(s_south_level);
                        mass_reg   <= LVL_W'(s_center_thickness) - eps_ext;
                        gone_reg   <= '0;
                        state_reg  <= ST_SUM;
                        k_reg      <= '0;
                        cnt_reg    <= '0;
                        acc_reg    <= SUM_W'(LVL_W'(s_center_thickness) - eps_ext);
                    end
                end
                ST_SUM: begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_next;
                    k_reg   <= k_reg + CELL_IDX_W'(1);
                    if (k_reg == CELL_IDX_W'(CELLS - 1)) begin
                        if (cnt_next == '0) begin
                            avg_reg   <= acc_next;
                            state_reg <= ST_ELIM;
                        end else begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        avg_reg   <= div_quo;
                        state_reg <= ST_ELIM;
                    end
                end
                ST_ELIM: begin
                    gone_reg <= gone_next;
                    k_reg    <= '0;
                    if (gone_next != gone_reg) begin
                        cnt_reg   <= '0;
                        acc_reg   <= SUM_W'(mass_reg);
                        state_reg <= ST_SUM;
                    end else begin
                        state_reg <= ST_FLOW;
                    end
                end
                ST_FLOW: begin
                    if (k_reg < CELL_IDX_W'(NEIGHBORS)) begin
                        diff_reg <= gone_reg[nb_idx] ? '0 : diff_full[DIFF_W-1:0];
                    end
                    prod_reg <= prod_next;
                    if (k_reg >= CELL_IDX_W'(2)) begin
                        res_reg[res_idx] <= sat_flow;
                    end
                    k_reg <= k_reg + CELL_IDX_W'(1);
                    if (k_reg == CELL_IDX_W'(NEIGHBORS + 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        flow_n_reg  <= res_reg[0];
                        flow_w_reg  <= res_reg[1];
                        flow_e_reg  <= res_reg[2];
                        flow_s_reg  <= res_reg[3];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_flow_north = flow_n_reg;
    assign m_flow_west  = flow_w_reg;
    assign m_flow_east  = flow_e_reg;
    assign m_flow_south = flow_s_reg;

endmodule
